FILE: design/grd_pkg.sv
package grd_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int XY_W         = 33;   // CORDIC vector, Q2.30 plus growth
    localparam int Z_W          = 25;   // residual angle, 1/2^24 turn units
    localparam int ATAN_W       = 22;
    localparam int FACE_W       = 16;
    localparam int ANG_W        = 16;
    localparam int POS_W        = 24;
    localparam int FRAC_W       = 16;
    localparam int PROD_W       = 49;
    localparam int SUM_W        = 50;
    localparam int SQ_W         = 31;   // square of a 16-bit magnitude
    localparam int QUO_W        = 48;
    localparam int DIV_SHIFT    = 28;
    localparam int NUM_HI       = QUO_W - DIV_SHIFT;
    localparam int ROOT_W       = 24;
    localparam int DIST_W       = 24;
    localparam int PART_W       = FRAC_W + 1;
    localparam int DIV_LAT      = QUO_W + 1;
    localparam int SQRT_LAT     = ROOT_W + 1;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [DIST_W-1:0]      DIST_MAX    = 24'hFFFFFF;
    localparam logic [QUO_W-1:0]       DIV_ONE     = QUO_W'(1) << DIV_SHIFT;

    function automatic logic [ATAN_W-1:0] grd_atan(input logic [3:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            4'd0:    v = 22'd2097152;
            4'd1:    v = 22'd1238021;
            4'd2:    v = 22'd654136;
            4'd3:    v = 22'd332050;
            4'd4:    v = 22'd166669;
            4'd5:    v = 22'd83416;
            4'd6:    v = 22'd41718;
            4'd7:    v = 22'd20860;
            4'd8:    v = 22'd10430;
            4'd9:    v = 22'd5215;
            4'd10:   v = 22'd2608;
            4'd11:   v = 22'd1304;
            4'd12:   v = 22'd652;
            4'd13:   v = 22'd326;
            4'd14:   v = 22'd163;
            default: v = 22'd81;
        endcase
        return v;
    endfunction

endpackage

FILE: design/grid_ray_dda_setup_unit.sv
// Ray setup for a grid raycaster: rotates the facing vector by the ray angle
// and gives per-axis cell-crossing lengths, first-boundary lengths and step
// directions for the grid walk that follows.
// Input channel (s_axis) carries position, facing vector and angle; output
// channel (m_axis) carries one result per input, in input order.
// The path from input transfer to output valid runs through 97 register
// stages: 17 CORDIC stages, 4 stages of rotate/square/range check, a 49-stage
// pipelined divider, a 25-stage square root and 2 stages for the boundary
// distance and the output register.
// Throughput is one item per cycle while the receiver does not stall; every
// stage is registered and valid bits travel with the data.
// When the receiver stalls with a result held, the whole pipeline holds and
// s_axis tready drops; nothing is lost or repeated. While the output register
// is empty or being drained, input is taken every cycle.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
module grid_ray_dda_setup_unit
    import grd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // pos_x[23:0], pos_y[47:24], face_x[63:48], face_y[79:64], ray_angle[95:80]
    input  logic [95:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // ray_dir_x[15:0], ray_dir_y[31:16], delta_x[55:32], delta_y[79:56],
    // side_x[103:80], side_y[127:104], step_x_pos[128], step_y_pos[129],
    // saturated[130], zero fill[135:131]
    output logic [135:0] o_m_axis_tdata
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam int BAND_LAT = DIV_LAT + SQRT_LAT;
    localparam int RND_POS  = 29;
    localparam int Q14_MAX  = 32767;
    localparam int Q14_MIN  = -32768;

    typedef struct packed {
        logic [FRAC_W-1:0]        frac_x;
        logic [FRAC_W-1:0]        frac_y;
        logic signed [FACE_W-1:0] fx;
        logic signed [FACE_W-1:0] fy;
        logic [1:0]               quad;
    } t_cside;

    typedef struct packed {
        logic [FRAC_W-1:0]        frac_x;
        logic [FRAC_W-1:0]        frac_y;
        logic signed [FACE_W-1:0] rx;
        logic signed [FACE_W-1:0] ry;
        logic                     sat_x;
        logic                     sat_y;
    } t_band;

    logic en;
    logic r_o_valid;

    assign en              = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    function automatic logic signed [FACE_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        r = (v + SUM_W'(64'sd1 <<< RND_POS)) >>> (RND_POS + 1);
        if (r > SUM_W'(Q14_MAX)) return FACE_W'(Q14_MAX);
        if (r < SUM_W'(Q14_MIN)) return FACE_W'(Q14_MIN);
        return r[FACE_W-1:0];
    endfunction

    // ---------------- CORDIC ----------------
    logic signed [XY_W-1:0] r_cx [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] r_cy [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  r_cz [0:CORDIC_STEPS-1];
    t_cside                 r_cs [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0]  r_cv;

    logic signed [XY_W-1:0] n_cx [0:CORDIC_STEPS-1];
    logic signed [XY_W-1:0] n_cy [0:CORDIC_STEPS-1];
    logic signed [Z_W-1:0]  n_cz [0:CORDIC_STEPS-1];
    logic signed [Z_W-1:0]  w_at [0:CORDIC_STEPS-1];

    always_comb begin
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            w_at[k] = $signed(Z_W'(grd_atan(4'(k))));
            if (!r_cz[k][Z_W-1]) begin
                n_cx[k] = r_cx[k] - (r_cy[k] >>> k);
                n_cy[k] = r_cy[k] + (r_cx[k] >>> k);
                n_cz[k] = r_cz[k] - w_at[k];
            end else begin
                n_cx[k] = r_cx[k] + (r_cy[k] >>> k);
                n_cy[k] = r_cy[k] - (r_cx[k] >>> k);
                n_cz[k] = r_cz[k] + w_at[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0]        <= CORDIC_GAIN;
            r_cy[0]        <= '0;
            r_cz[0]        <= $signed(Z_W'({i_s_axis_tdata[93:80], 8'd0}));
            r_cs[0].frac_x <= i_s_axis_tdata[15:0];
            r_cs[0].frac_y <= i_s_axis_tdata[39:24];
            r_cs[0].fx     <= i_s_axis_tdata[63:48];
            r_cs[0].fy     <= i_s_axis_tdata[79:64];
            r_cs[0].quad   <= i_s_axis_tdata[95:94];
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_cx[k+1] <= n_cx[k];
                r_cy[k+1] <= n_cy[k];
                r_cs[k+1] <= r_cs[k];
            end
            for (int k = 0; k < CORDIC_STEPS - 1; k++) begin
                r_cz[k+1] <= n_cz[k];
            end
        end
    end

    // ---------------- rotate ----------------
    logic signed [XY_W-1:0] w_c, w_s;
    t_cside                 w_cs;

    assign w_cs = r_cs[CORDIC_STEPS];

    always_comb begin
        case (w_cs.quad)
            QUAD_0: begin
                w_c = r_cx[CORDIC_STEPS];
                w_s = r_cy[CORDIC_STEPS];
            end
            QUAD_1: begin
                w_c = -r_cy[CORDIC_STEPS];
                w_s = r_cx[CORDIC_STEPS];
            end
            QUAD_2: begin
                w_c = -r_cx[CORDIC_STEPS];
                w_s = -r_cy[CORDIC_STEPS];
            end
            default: begin
                w_c = r_cy[CORDIC_STEPS];
                w_s = -r_cx[CORDIC_STEPS];
            end
        endcase
    end

    logic                     r_m_valid;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic [FRAC_W-1:0]        r_m_frac_x, r_m_frac_y;

    logic                     r_r_valid;
    logic signed [FACE_W-1:0] r_rx, r_ry;
    logic [FRAC_W-1:0]        r_r_frac_x, r_r_frac_y;

    logic                     r_q_valid;
    logic [SQ_W-1:0]          r_ax2, r_ay2;
    logic signed [FACE_W-1:0] r_q_rx, r_q_ry;
    logic [FRAC_W-1:0]        r_q_frac_x, r_q_frac_y;

    logic                     r_t_valid;
    logic [SQ_W-1:0]          r_t_ax2, r_t_ay2;
    t_band                    r_t_band;

    logic [FACE_W-1:0]        w_ax, w_ay;
    logic [SQ_W+19:0]         w_lim_x, w_lim_y;

    assign w_ax    = r_rx[FACE_W-1] ? FACE_W'(-r_rx) : r_rx;
    assign w_ay    = r_ry[FACE_W-1] ? FACE_W'(-r_ry) : r_ry;
    // quotient plus one overflows 48 bits when b^2 >= (2^20 - 1) * a^2
    assign w_lim_x = {r_ax2, 20'd0} - (SQ_W+20)'(r_ax2);
    assign w_lim_y = {r_ay2, 20'd0} - (SQ_W+20)'(r_ay2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0       <= w_cs.fx * w_c;
            r_p1       <= w_cs.fy * w_s;
            r_p2       <= w_cs.fx * w_s;
            r_p3       <= w_cs.fy * w_c;
            r_m_frac_x <= w_cs.frac_x;
            r_m_frac_y <= w_cs.frac_y;

            r_rx       <= round_sat(SUM_W'(r_p0) - SUM_W'(r_p1));
            r_ry       <= round_sat(SUM_W'(r_p2) + SUM_W'(r_p3));
            r_r_frac_x <= r_m_frac_x;
            r_r_frac_y <= r_m_frac_y;

            r_ax2      <= SQ_W'(w_ax) * SQ_W'(w_ax);
            r_ay2      <= SQ_W'(w_ay) * SQ_W'(w_ay);
            r_q_rx     <= r_rx;
            r_q_ry     <= r_ry;
            r_q_frac_x <= r_r_frac_x;
            r_q_frac_y <= r_r_frac_y;

            r_t_ax2         <= r_ax2;
            r_t_ay2         <= r_ay2;
            r_t_band.frac_x <= r_q_frac_x;
            r_t_band.frac_y <= r_q_frac_y;
            r_t_band.rx     <= r_q_rx;
            r_t_band.ry     <= r_q_ry;
            r_t_band.sat_x  <= (r_ax2 == '0) || ((SQ_W+20)'(r_ay2) >= w_lim_x);
            r_t_band.sat_y  <= (r_ay2 == '0) || ((SQ_W+20)'(r_ax2) >= w_lim_y);
        end
    end

    // ---------------- divide and square root ----------------
    logic [QUO_W-1:0]  w_quo_x, w_quo_y;
    logic [ROOT_W-1:0] w_root_x, w_root_y;

    grd_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_t_ay2),
        .i_den (r_t_ax2),
        .o_quo (w_quo_x)
    );

    grd_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_t_ax2),
        .i_den (r_t_ay2),
        .o_quo (w_quo_y)
    );

    grd_sqrt u_sqrt_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (w_quo_x + DIV_ONE),
        .o_root (w_root_x)
    );

    grd_sqrt u_sqrt_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (w_quo_y + DIV_ONE),
        .o_root (w_root_y)
    );

    t_band               r_band [0:BAND_LAT-1];
    logic [BAND_LAT-1:0] r_bv;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_band[0] <= r_t_band;
            for (int k = 0; k < BAND_LAT - 1; k++) begin
                r_band[k+1] <= r_band[k];
            end
        end
    end

    // ---------------- boundary distance ----------------
    t_band                    w_b;
    logic                     w_up_x, w_up_y;

    assign w_b    = r_band[BAND_LAT-1];
    assign w_up_x = !w_b.rx[FACE_W-1] && (w_b.rx != '0);
    assign w_up_y = !w_b.ry[FACE_W-1] && (w_b.ry != '0);

    logic                     r_s_valid;
    logic [DIST_W-1:0]        r_dx, r_dy;
    logic [PART_W-1:0]        r_part_x, r_part_y;
    logic signed [FACE_W-1:0] r_s_rx, r_s_ry;
    logic                     r_s_up_x, r_s_up_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx     <= w_b.sat_x ? DIST_MAX : w_root_x;
            r_dy     <= w_b.sat_y ? DIST_MAX : w_root_y;
            r_part_x <= w_up_x ? PART_W'(PART_W'(1) << FRAC_W) - PART_W'(w_b.frac_x)
                               : PART_W'(w_b.frac_x);
            r_part_y <= w_up_y ? PART_W'(PART_W'(1) << FRAC_W) - PART_W'(w_b.frac_y)
                               : PART_W'(w_b.frac_y);
            r_s_rx   <= w_b.rx;
            r_s_ry   <= w_b.ry;
            r_s_up_x <= w_up_x;
            r_s_up_y <= w_up_y;
        end
    end

    logic [PART_W+DIST_W-1:0] w_prod_x, w_prod_y;
    logic [PART_W+DIST_W-FRAC_W-1:0] w_sh_x, w_sh_y;
    logic [DIST_W-1:0]        w_side_x, w_side_y;
    logic                     w_dmax_x, w_dmax_y, w_ov_x, w_ov_y;

    assign w_prod_x = r_part_x * r_dx;
    assign w_prod_y = r_part_y * r_dy;
    assign w_sh_x   = w_prod_x[PART_W+DIST_W-1:FRAC_W];
    assign w_sh_y   = w_prod_y[PART_W+DIST_W-1:FRAC_W];
    assign w_dmax_x = r_dx == DIST_MAX;
    assign w_dmax_y = r_dy == DIST_MAX;
    assign w_ov_x   = w_sh_x > (PART_W+DIST_W-FRAC_W)'(DIST_MAX);
    assign w_ov_y   = w_sh_y > (PART_W+DIST_W-FRAC_W)'(DIST_MAX);
    assign w_side_x = (w_dmax_x || w_ov_x) ? DIST_MAX : w_sh_x[DIST_W-1:0];
    assign w_side_y = (w_dmax_y || w_ov_y) ? DIST_MAX : w_sh_y[DIST_W-1:0];

    logic [135:0] r_o_data;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= {5'd0,
                         w_dmax_x || w_dmax_y || w_ov_x || w_ov_y,
                         r_s_up_y, r_s_up_x,
                         w_side_y, w_side_x, r_dy, r_dx,
                         r_s_ry, r_s_rx};
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv      <= '0;
            r_m_valid <= 1'b0;
            r_r_valid <= 1'b0;
            r_q_valid <= 1'b0;
            r_t_valid <= 1'b0;
            r_bv      <= '0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_cv      <= {r_cv[CORDIC_STEPS-1:0], i_s_axis_tvalid};
            r_m_valid <= r_cv[CORDIC_STEPS];
            r_r_valid <= r_m_valid;
            r_q_valid <= r_r_valid;
            r_t_valid <= r_q_valid;
            r_bv      <= {r_bv[BAND_LAT-2:0], r_t_valid};
            r_s_valid <= r_bv[BAND_LAT-1];
            r_o_valid <= r_s_valid;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

endmodule

FILE: design/grd_div.sv
module grd_div
    import grd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SQ_W-1:0]   i_num,
    input  logic [SQ_W-1:0]   i_den,
    output logic [QUO_W-1:0]  o_quo
);

    // Restoring division of (i_num << DIV_SHIFT) by i_den, one quotient bit per stage.
    logic [SQ_W-1:0]  r_rem [0:QUO_W-1];
    logic [QUO_W-1:0] r_lo  [0:QUO_W-1];
    logic [SQ_W-1:0]  r_den [0:QUO_W-1];
    logic [QUO_W-1:0] r_quo [1:QUO_W];

    logic [SQ_W-1:0]  n_rem [0:QUO_W-1];
    logic [QUO_W-1:0] n_quo [0:QUO_W-1];
    logic [QUO_W-1:0] w_qprev [0:QUO_W-1];
    logic [SQ_W:0]    w_try [0:QUO_W-1];
    logic             w_ge  [0:QUO_W-1];

    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            w_qprev[k] = (k == 0) ? '0 : r_quo[(k == 0) ? 1 : k];
            w_try[k]   = {r_rem[k], r_lo[k][QUO_W-1]};
            w_ge[k]    = w_try[k] >= {1'b0, r_den[k]};
            n_rem[k]   = w_ge[k] ? SQ_W'(w_try[k] - {1'b0, r_den[k]}) : w_try[k][SQ_W-1:0];
            n_quo[k]   = {w_qprev[k][QUO_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= SQ_W'(i_num[SQ_W-1:NUM_HI]);
            r_lo[0]  <= {i_num[NUM_HI-1:0], DIV_SHIFT'(0)};
            r_den[0] <= i_den;
            for (int k = 0; k < QUO_W - 1; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_lo[k+1]  <= r_lo[k] << 1;
                r_den[k+1] <= r_den[k];
            end
            for (int k = 0; k < QUO_W; k++) begin
                r_quo[k+1] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[QUO_W];

endmodule

FILE: design/grd_sqrt.sv
module grd_sqrt
    import grd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [QUO_W-1:0]  i_val,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W = ROOT_W + 2;

    // Digit-by-digit square root, one root bit per stage.
    logic [QUO_W-1:0]  r_v    [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [1:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [1:ROOT_W];

    logic [REM_W-1:0]  w_rprev [0:ROOT_W-1];
    logic [ROOT_W-1:0] w_oprev [0:ROOT_W-1];
    logic [REM_W+1:0]  w_try   [0:ROOT_W-1];
    logic [REM_W+1:0]  w_trial [0:ROOT_W-1];
    logic              w_ge    [0:ROOT_W-1];
    logic [REM_W-1:0]  n_rem   [0:ROOT_W-1];
    logic [ROOT_W-1:0] n_root  [0:ROOT_W-1];

    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            w_rprev[k] = (k == 0) ? '0 : r_rem[(k == 0) ? 1 : k];
            w_oprev[k] = (k == 0) ? '0 : r_root[(k == 0) ? 1 : k];
            w_try[k]   = {w_rprev[k], r_v[k][QUO_W-1:QUO_W-2]};
            w_trial[k] = (REM_W+2)'({w_oprev[k], 2'b01});
            w_ge[k]    = w_try[k] >= w_trial[k];
            n_rem[k]   = w_ge[k] ? REM_W'(w_try[k] - w_trial[k]) : REM_W'(w_try[k]);
            n_root[k]  = {w_oprev[k][ROOT_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0] <= i_val;
            for (int k = 0; k < ROOT_W - 1; k++) begin
                r_v[k+1]   <= r_v[k] << 2;
                r_rem[k+1] <= n_rem[k];
            end
            for (int k = 0; k < ROOT_W; k++) begin
                r_root[k+1] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[ROOT_W];

endmodule
